FILE: hdl/sucf_pkg.sv
package sucf_pkg;

  localparam int ACC_W       = 32;
  localparam int SAMPLE_W    = 16;
  localparam int SHIFT_W     = 5;
  localparam int NUM_FRAMES  = 4;
  localparam int NUM_SAMPLES = 2 * NUM_FRAMES;
  localparam int NUM_RESULTS = 2 * NUM_FRAMES;
  localparam int RESULT_IDX_W = $clog2(NUM_RESULTS);

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd8;

  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    acc_t left_0;
    acc_t right_0;
    acc_t left_1;
    acc_t right_1;
    acc_t left_2;
    acc_t right_2;
    acc_t left_3;
    acc_t right_3;
    logic buffer_end;
  } in_item_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  typedef pair_t [NUM_RESULTS-1:0] group_t;

  // floor of (a + b) / 2
  function automatic sample_t midpoint(input sample_t a, input sample_t b);
    logic signed [SAMPLE_W:0] sum;
    sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    return sum[SAMPLE_W:1];
  endfunction

endpackage

FILE: hdl/sucf_in_if.sv
interface sucf_in_if;
  import sucf_pkg::*;

  logic valid;
  logic ready;
  acc_t left_0;
  acc_t right_0;
  acc_t left_1;
  acc_t right_1;
  acc_t left_2;
  acc_t right_2;
  acc_t left_3;
  acc_t right_3;
  logic buffer_end;

  modport source (
    output valid, left_0, right_0, left_1, right_1, left_2, right_2, left_3, right_3,
    output buffer_end,
    input  ready
  );

  modport sink (
    input  valid, left_0, right_0, left_1, right_1, left_2, right_2, left_3, right_3,
    input  buffer_end,
    output ready
  );
endinterface

FILE: hdl/sucf_out_if.sv
interface sucf_out_if;
  import sucf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;
  logic    group_last;
  logic    buffer_last;

  modport source (
    output valid, out_left, out_right, group_last, buffer_last,
    input  ready
  );

  modport sink (
    input  valid, out_left, out_right, group_last, buffer_last,
    output ready
  );
endinterface

FILE: hdl/sucf_group_calc.sv
module sucf_group_calc (
  input  sucf_pkg::in_item_t                item,
  input  logic [sucf_pkg::SHIFT_W-1:0]      shift,
  input  sucf_pkg::pair_t                   prev,
  output sucf_pkg::group_t                  results,
  output sucf_pkg::pair_t                   last_pair
);
  import sucf_pkg::*;

  acc_t                   acc     [NUM_SAMPLES];
  acc_t                   shifted [NUM_SAMPLES];
  sample_t                sat     [NUM_SAMPLES];
  logic [NUM_SAMPLES-1:0] fits;
  logic                   overflow;
  sample_t                prev_l  [NUM_FRAMES];
  sample_t                prev_r  [NUM_FRAMES];

  always_comb begin
    acc[0] = item.left_0;
    acc[1] = item.right_0;
    acc[2] = item.left_1;
    acc[3] = item.right_1;
    acc[4] = item.left_2;
    acc[5] = item.right_2;
    acc[6] = item.left_3;
    acc[7] = item.right_3;

    // shift, range check and saturate each sample
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      shifted[k] = acc[k] >>> shift;
      fits[k] = (&shifted[k][ACC_W-1:SAMPLE_W-1]) || !(|shifted[k][ACC_W-1:SAMPLE_W-1]);
      if (fits[k]) begin
        sat[k] = shifted[k][SAMPLE_W-1:0];
      end else if (shifted[k][ACC_W-1]) begin
        sat[k] = SAMPLE_MIN;
      end else begin
        sat[k] = SAMPLE_MAX;
      end
    end
    overflow = !(&fits);

    prev_l[0] = prev.left;
    prev_r[0] = prev.right;
    for (int f = 1; f < NUM_FRAMES; f++) begin
      prev_l[f] = sat[2*f-2];
      prev_r[f] = sat[2*f-1];
    end

    for (int f = 0; f < NUM_FRAMES; f++) begin
      results[2*f+1].left  = sat[2*f];
      results[2*f+1].right = sat[2*f+1];
      if (overflow) begin
        results[2*f].left  = sat[2*f];
        results[2*f].right = sat[2*f+1];
      end else begin
        results[2*f].left  = midpoint(sat[2*f], prev_l[f]);
        results[2*f].right = midpoint(sat[2*f+1], prev_r[f]);
      end
    end

    last_pair.left  = sat[NUM_SAMPLES-2];
    last_pair.right = sat[NUM_SAMPLES-1];
  end
endmodule

FILE: hdl/sucf_result_buf.sv
module sucf_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sucf_pkg::group_t  results,
  input  logic              buffer_end,
  input  sucf_pkg::pair_t   new_prev,
  output sucf_pkg::pair_t   prev,
  output logic              can_load,
  sucf_out_if.source        out_ch
);
  import sucf_pkg::*;

  logic                    busy;
  logic [RESULT_IDX_W-1:0] idx;
  group_t                  res;
  logic                    buf_end;
  logic                    at_last;
  logic                    take;

  assign at_last  = (idx == RESULT_IDX_W'(NUM_RESULTS - 1));
  assign take     = busy && out_ch.ready;
  assign can_load = !busy || (take && at_last);

  assign out_ch.valid       = busy;
  assign out_ch.out_left    = res[idx].left;
  assign out_ch.out_right   = res[idx].right;
  assign out_ch.group_last  = at_last;
  assign out_ch.buffer_last = at_last && buf_end;

  // control and history
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      prev <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
        prev <= new_prev;
      end else if (take) begin
        if (at_last) begin
          busy <= 1'b0;
          idx  <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res     <= results;
      buf_end <= buffer_end;
    end
  end
endmodule

FILE: hdl/stereo_upsample_clamp_output.sv
// Stereo 2x upsampler with 16-bit clamping. Each input transaction carries one group of four
// stereo frames of 32-bit accumulators; the block shifts them right by output_shift, and gives
// eight 16-bit stereo result transactions, one per cycle while results.ready is high, the eighth
// flagged group_last (and buffer_last when the group had buffer_end). Without overflow each
// frame yields its midpoint with the previous sample, then the sample; if any sample of the
// group overflows, the whole group is clamped and each pair is repeated. A group passes an
// input register, then is computed in one pass into an eight-entry result buffer, from which
// the results are offered. The output buffer drains one result per cycle while results.ready
// is high; the next group waits in the input register and moves into the buffer as the eighth
// result is taken. The midpoint history is kept across groups and buffers and cleared only by
// reset. Write output_shift only while the block is idle.
module stereo_upsample_clamp_output (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [sucf_pkg::SHIFT_W-1:0] cfg_wr_data,
  sucf_in_if.sink                      samples,
  sucf_out_if.source                   results
);
  import sucf_pkg::*;

  logic [SHIFT_W-1:0] output_shift;
  logic               in_full;
  in_item_t           in_item;
  in_item_t           in_next;
  logic               can_load;
  logic               load;
  group_t             calc_results;
  pair_t              calc_last;
  pair_t              prev;

  assign load          = in_full && can_load;
  assign samples.ready = !in_full || can_load;

  always_comb begin
    in_next.left_0     = samples.left_0;
    in_next.right_0    = samples.right_0;
    in_next.left_1     = samples.left_1;
    in_next.right_1    = samples.right_1;
    in_next.left_2     = samples.left_2;
    in_next.right_2    = samples.right_2;
    in_next.left_3     = samples.left_3;
    in_next.right_3    = samples.right_3;
    in_next.buffer_end = samples.buffer_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_shift <= SHIFT_RESET;
      in_full      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        output_shift <= cfg_wr_data;
      end
      if (samples.valid && samples.ready) begin
        in_full <= 1'b1;
      end else if (load) begin
        in_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_item <= in_next;
    end
  end

  sucf_group_calc u_calc (
    .item      (in_item),
    .shift     (output_shift),
    .prev      (prev),
    .results   (calc_results),
    .last_pair (calc_last)
  );

  sucf_result_buf u_result_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .results    (calc_results),
    .buffer_end (in_item.buffer_end),
    .new_prev   (calc_last),
    .prev       (prev),
    .can_load   (can_load),
    .out_ch     (results)
  );
endmodule

FILE: tb/stereo_upsample_clamp_output_checker.sv
`timescale 1ns / 1ps

module stereo_upsample_clamp_output_checker
  import sucf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SHIFT_W-1:0] cfg_wr_data,
  sucf_in_if                 samples,
  sucf_out_if                results,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    group_last;
    logic    buffer_last;
  } upsample_result_t;

  upsample_result_t   expected_q[$];
  logic [SHIFT_W-1:0] shift_amt;
  sample_t            hist_left;
  sample_t            hist_right;

  always @(posedge clk) begin : predict_and_compare
    acc_t             acc     [NUM_SAMPLES];
    acc_t             shifted [NUM_SAMPLES];
    sample_t          clamped [NUM_SAMPLES];
    logic             over;
    upsample_result_t exp_r;
    upsample_result_t mid_r;
    int               lsum;
    int               rsum;
    int               errs;

    if (rst) begin
      shift_amt  = SHIFT_RESET;
      hist_left  = '0;
      hist_right = '0;
      expected_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      errs = 0;
      if (cfg_wr_en) begin
        shift_amt = cfg_wr_data;
      end

      // compare before predicting so a result never matches its own transaction
      if (results.valid && results.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: out_left %0d out_right %0d",
                 results.out_left, results.out_right);
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          if (results.out_left !== exp_r.left) begin
            $error("out_left: expected %0d, actual %0d", exp_r.left, results.out_left);
            errs++;
          end
          if (results.out_right !== exp_r.right) begin
            $error("out_right: expected %0d, actual %0d", exp_r.right, results.out_right);
            errs++;
          end
          if (results.group_last !== exp_r.group_last) begin
            $error("group_last: expected %0b, actual %0b",
                   exp_r.group_last, results.group_last);
            errs++;
          end
          if (results.buffer_last !== exp_r.buffer_last) begin
            $error("buffer_last: expected %0b, actual %0b",
                   exp_r.buffer_last, results.buffer_last);
            errs++;
          end
        end
      end

      if (samples.valid && samples.ready) begin
        acc = '{samples.left_0, samples.right_0, samples.left_1, samples.right_1,
                samples.left_2, samples.right_2, samples.left_3, samples.right_3};
        over = 1'b0;
        for (int k = 0; k < NUM_SAMPLES; k++) begin
          shifted[k] = acc[k] >>> shift_amt;
          if (shifted[k] > 32767) begin
            clamped[k] = SAMPLE_MAX;
            over = 1'b1;
          end else if (shifted[k] < -32768) begin
            clamped[k] = SAMPLE_MIN;
            over = 1'b1;
          end else begin
            clamped[k] = shifted[k][SAMPLE_W-1:0];
          end
        end
        for (int f = 0; f < NUM_FRAMES; f++) begin
          exp_r.left        = clamped[2*f];
          exp_r.right       = clamped[2*f+1];
          exp_r.group_last  = (f == NUM_FRAMES - 1);
          exp_r.buffer_last = (f == NUM_FRAMES - 1) && samples.buffer_end;
          mid_r.group_last  = 1'b0;
          mid_r.buffer_last = 1'b0;
          if (over) begin
            mid_r.left  = exp_r.left;
            mid_r.right = exp_r.right;
          end else begin
            // floor midpoint with the previous sample of each channel
            lsum = int'(exp_r.left) + int'(hist_left);
            rsum = int'(exp_r.right) + int'(hist_right);
            mid_r.left  = sample_t'(lsum >>> 1);
            mid_r.right = sample_t'(rsum >>> 1);
          end
          expected_q.push_back(mid_r);
          expected_q.push_back(exp_r);
          hist_left  = exp_r.left;
          hist_right = exp_r.right;
        end
      end

      fail_count <= fail_count + errs;
      pending    <= expected_q.size();
    end
  end

endmodule

FILE: tb/stereo_upsample_clamp_output_tb.sv
`timescale 1ns / 1ps

module stereo_upsample_clamp_output_tb;
  import sucf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 45;
  localparam int NUM_PHASES   = 8;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum int {SMP_IN_RANGE, SMP_EDGE, SMP_WIDE} sample_kind_e;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [SHIFT_W-1:0] cfg_wr_data;
  logic               hold_trigger;
  int                 fail_count;
  int                 pending;

  sucf_in_if  samples ();
  sucf_out_if results ();

  stereo_upsample_clamp_output uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .samples     (samples),
    .results     (results)
  );

  stereo_upsample_clamp_output_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .samples     (samples),
    .results     (results),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic in_item_t group_of(input acc_t l0, input acc_t r0, input acc_t l1,
                                        input acc_t r1, input acc_t l2, input acc_t r2,
                                        input acc_t l3, input acc_t r3, input logic be);
    in_item_t g;
    g.left_0 = l0; g.right_0 = r0;
    g.left_1 = l1; g.right_1 = r1;
    g.left_2 = l2; g.right_2 = r2;
    g.left_3 = l3; g.right_3 = r3;
    g.buffer_end = be;
    return g;
  endfunction

  // accumulator whose shifted value lands where kind asks, with random fraction bits
  function automatic acc_t make_sample(input logic [SHIFT_W-1:0] s, input sample_kind_e kind);
    sample_t raw16;
    int      v;
    acc_t    low_mask;
    low_mask = ~(32'hFFFF_FFFF << s);
    case (kind)
      SMP_IN_RANGE: begin
        raw16 = sample_t'($urandom);
        v = raw16;
      end
      SMP_EDGE: begin
        case ($urandom_range(0, 5))
          0: v = 32767;
          1: v = -32768;
          2: v = 32768;
          3: v = -32769;
          4: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return acc_t'($urandom);
    endcase
    return acc_t'((v <<< s) | ($urandom & low_mask));
  endfunction

  task automatic send_group(input in_item_t g);
    samples.valid      <= 1'b1;
    samples.left_0     <= g.left_0;
    samples.right_0    <= g.right_0;
    samples.left_1     <= g.left_1;
    samples.right_1    <= g.right_1;
    samples.left_2     <= g.left_2;
    samples.right_2    <= g.right_2;
    samples.left_3     <= g.left_3;
    samples.right_3    <= g.right_3;
    samples.buffer_end <= g.buffer_end;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
  endtask

  task automatic drain_all();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] value);
    drain_all();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_random_group(input logic [SHIFT_W-1:0] s);
    acc_t         a [NUM_SAMPLES];
    sample_kind_e kind;
    logic         clean;
    clean = ($urandom_range(0, 9) < 6);
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      kind = clean ? SMP_IN_RANGE : sample_kind_e'($urandom_range(0, 2));
      a[k] = make_sample(s, kind);
    end
    send_group(group_of(a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7],
                        $urandom_range(0, 3) == 0));
  endtask

  // receiver side
  initial begin : result_drain
    rx_mode_e mode;
    int       mode_left;
    int       hold_cnt;
    logic     hold_done;
    int       tick;
    mode_left = 0;
    hold_cnt  = 0;
    hold_done = 1'b0;
    tick      = 0;
    mode      = RX_ALWAYS;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_cnt > 0) begin
        results.ready <= 1'b0;
        hold_cnt--;
        if (hold_cnt == 0) hold_done = 1'b1;
      end else if (hold_trigger && !hold_done) begin
        results.ready <= 1'b0;
        hold_cnt = HOLD_CYCLES;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS:   results.ready <= 1'b1;
          RX_MOSTLY:   results.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE:   results.ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: results.ready <= ((tick % 7) < 4);
          default:     results.ready <= 1'b1;
        endcase
      end
    end
  end

  // timeout
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [SHIFT_W-1:0] phase_shift;
    logic               gaps_on;
    int                 burst_left;
    int                 gap;

    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    hold_trigger       <= 1'b0;
    samples.valid      <= 1'b0;
    samples.left_0     <= '0;
    samples.right_0    <= '0;
    samples.left_1     <= '0;
    samples.right_1    <= '0;
    samples.left_2     <= '0;
    samples.right_2    <= '0;
    samples.left_3     <= '0;
    samples.right_3    <= '0;
    samples.buffer_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset shift of 8
    send_group(group_of(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_group(group_of(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0180, 32'hFFFF_FF00,
                        32'h007F_FF00, 32'hFF80_0000, 32'h0012_3456, 32'hFFED_CBA9, 1'b1));
    send_group(group_of(32'h0000_0100, 32'hFFFF_FE00, 32'h0000_0300, 32'hFFFF_FB00,
                        32'h0080_0000, 32'h0000_0500, 32'h0000_0700, 32'hFFFF_F900, 1'b0));
    send_group(group_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    send_group(group_of(32'h0000_1000, 32'hFF7F_FFFF, 32'h0000_2000, 32'h0000_0100,
                        32'hFFFF_FF00, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
    send_group(group_of(32'h007F_FFFF, 32'hFF80_0000, 32'h007F_FFFF, 32'hFF80_0000,
                        32'hFF80_0000, 32'h007F_FFFF, 32'hFF80_0000, 32'h007F_FFFF, 1'b0));
    send_group(group_of(32'hFFFF_FF00, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0100,
                        32'hFFFF_FE00, 32'h0000_0300, 32'h0000_0000, 32'h0000_0000, 1'b1));

    write_shift(5'd0);
    send_group(group_of(32767, -32768, 0, 1, -1, 100, -100, 12345, 1'b0));
    send_group(group_of(1, 3, 32768, -7, 5, 9, -11, 13, 1'b1));
    send_group(group_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send_group(group_of(-32769, 2, 4, 6, 8, 10, 12, 14, 1'b0));
    send_group(group_of(-32768, 32767, -32767, 32766, 3, -3, 32767, -32768, 1'b0));

    write_shift(5'd31);
    send_group(group_of(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF,
                        32'h0000_0001, 32'h8000_0001, 32'h4000_0000, 32'hC000_0000, 1'b1));
    send_group(group_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                        32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0));

    write_shift(5'd16);
    send_group(group_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h0001_FFFF, 32'hFFFE_0000, 32'h0000_FFFF, 32'hFFFF_0001, 1'b1));
    send_group(group_of(32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC, 1'b0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_shift = 5'd8;
        1: phase_shift = 5'd0;
        2: phase_shift = 5'd31;
        3: phase_shift = 5'd16;
        4: phase_shift = 5'd15;
        5: phase_shift = 5'd17;
        default: phase_shift = SHIFT_W'($urandom);
      endcase
      write_shift(phase_shift);
      if (p == 1) hold_trigger <= 1'b1;
      gaps_on    = (p != 3);
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          gap = gaps_on ? $urandom_range(0, 6) : 0;
          if (gap > 0) begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 12);
        end
        send_random_group(phase_shift);
        burst_left--;
      end
    end

    drain_all();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
